[hdl/clpr_pkg.sv]
// clpr_pkg: shared types and constants of the closest-point-on-line core
// no dependencies
`timescale 1ns / 1ps

package clpr_pkg;

	// stage enable and the valid bit entering a delay chain
	typedef struct packed {
		logic en;
		logic valid;
	} pipe_ctl_t;

	// digit widths of the partial-product multipliers
	localparam int MUL_DIGIT_WIDE   = 16;
	localparam int MUL_DIGIT_NARROW = 8;

endpackage

[hdl/clpr_query_if.sv]
// clpr_query_if: query channel, a ray and a line in signed Q16.16
// no dependencies
`timescale 1ns / 1ps

interface clpr_query_if #(parameter int COORD_BITS = 32);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] ray_origin_x;
	logic signed [COORD_BITS-1:0] ray_origin_y;
	logic signed [COORD_BITS-1:0] ray_origin_z;
	logic signed [COORD_BITS-1:0] ray_dir_x;
	logic signed [COORD_BITS-1:0] ray_dir_y;
	logic signed [COORD_BITS-1:0] ray_dir_z;
	logic signed [COORD_BITS-1:0] seg_start_x;
	logic signed [COORD_BITS-1:0] seg_start_y;
	logic signed [COORD_BITS-1:0] seg_start_z;
	logic signed [COORD_BITS-1:0] seg_end_x;
	logic signed [COORD_BITS-1:0] seg_end_y;
	logic signed [COORD_BITS-1:0] seg_end_z;

	modport source (
		output valid, ray_origin_x, ray_origin_y, ray_origin_z,
		output ray_dir_x, ray_dir_y, ray_dir_z,
		output seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y, seg_end_z,
		input ready
	);
	modport sink (
		input valid, ray_origin_x, ray_origin_y, ray_origin_z,
		input ray_dir_x, ray_dir_y, ray_dir_z,
		input seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y, seg_end_z,
		output ready
	);
endinterface

[hdl/clpr_result_if.sv]
// clpr_result_if: result channel, the closest point and its flags
// no dependencies
`timescale 1ns / 1ps

interface clpr_result_if #(parameter int COORD_BITS = 32);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] near_x;
	logic signed [COORD_BITS-1:0] near_y;
	logic signed [COORD_BITS-1:0] near_z;
	logic parallel_flag;
	logic clipped_flag;

	modport source (
		output valid, near_x, near_y, near_z, parallel_flag, clipped_flag,
		input ready
	);
	modport sink (
		input valid, near_x, near_y, near_z, parallel_flag, clipped_flag,
		output ready
	);
endinterface

[hdl/clpr_pipe.sv]
// clpr_pipe: delay line for side data with its valid bit
// depends on clpr_pkg
`timescale 1ns / 1ps

module clpr_pipe #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  clpr_pkg::pipe_ctl_t ctl,
	input  logic [W-1:0]        d,
	output logic [W-1:0]        q,
	output logic                valid
);
	import clpr_pkg::*;

	logic         v_s [DEPTH];
	logic [W-1:0] d_s [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) v_s[i] <= 1'b0;
		end else if (ctl.en) begin
			v_s[0] <= ctl.valid;
			for (int i = 1; i < DEPTH; i++) v_s[i] <= v_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			d_s[0] <= d;
			for (int i = 1; i < DEPTH; i++) d_s[i] <= d_s[i-1];
		end
	end

	assign q     = d_s[DEPTH-1];
	assign valid = v_s[DEPTH-1];

endmodule

[hdl/clpr_mul.sv]
// clpr_mul: signed multiplier, one digit of b per pipeline stage
// depends on nothing but the enclosing pipeline's enable
`timescale 1ns / 1ps

module clpr_mul #(
	parameter int AW  = 16,
	parameter int BW  = 16,
	parameter int DGW = 8
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	output logic signed [AW+BW-1:0] p
);
	localparam int ND  = (BW + DGW - 1) / DGW;
	localparam int BPW = ND * DGW;
	localparam int PW  = AW + BW;

	logic signed [AW-1:0]  a_s   [ND];
	logic signed [BPW-1:0] b_s   [ND];
	logic signed [PW-1:0]  acc_s [ND];

	for (genvar i = 0; i < ND; i++) begin : g_st
		logic signed [AW-1:0]    a_in;
		logic signed [BPW-1:0]   b_in;
		logic signed [PW-1:0]    acc_in;
		logic signed [DGW:0]     dig;
		logic signed [AW+DGW:0]  pp;
		logic signed [PW-1:0]    pp_sh;

		if (i == 0) begin : g_first
			assign a_in   = a;
			assign b_in   = BPW'(b);
			assign acc_in = '0;
		end else begin : g_next
			assign a_in   = a_s[i-1];
			assign b_in   = b_s[i-1];
			assign acc_in = acc_s[i-1];
		end

		// only the top digit carries the sign
		if (i == ND - 1) begin : g_top
			assign dig = {b_in[BPW-1], b_in[i*DGW +: DGW]};
		end else begin : g_low
			assign dig = {1'b0, b_in[i*DGW +: DGW]};
		end

		assign pp    = a_in * dig;
		assign pp_sh = PW'(pp) <<< (i * DGW);

		always_ff @(posedge clk) begin
			if (en) begin
				a_s[i]   <= a_in;
				b_s[i]   <= b_in;
				acc_s[i] <= acc_in + pp_sh;
			end
		end
	end

	assign p = acc_s[ND-1];

endmodule

[hdl/clpr_div.sv]
// clpr_div: pipelined restoring divider, one quotient bit per stage,
// rounding to nearest and overflow detection; depends on clpr_pkg
`timescale 1ns / 1ps

module clpr_div #(
	parameter int NW = 32,
	parameter int DW = 16,
	parameter int QW = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  clpr_pkg::pipe_ctl_t ctl,
	input  logic [NW-1:0]       n,
	input  logic [DW-1:0]       d,
	output logic [QW:0]         qm,
	output logic                valid
);
	import clpr_pkg::*;

	localparam int CW = NW + 1;

	logic [NW-1:0] rem_s [QW+1];
	logic [DW-1:0] d_s   [QW+1];
	logic [QW-1:0] q_s   [QW+1];
	logic          ovf_s [QW+1];
	logic          v_s   [QW+1];
	logic [QW:0]   qm_q;
	logic          v_q;
	logic          ovf;
	logic          r2;

	// quotient would not fit in QW bits
	assign ovf = CW'(n) >= (CW'(d) << QW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= QW; i++) v_s[i] <= 1'b0;
			v_q <= 1'b0;
		end else if (ctl.en) begin
			v_s[0] <= ctl.valid;
			for (int i = 1; i <= QW; i++) v_s[i] <= v_s[i-1];
			v_q <= v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			rem_s[0] <= ovf ? '0 : n;
			d_s[0]   <= d;
			q_s[0]   <= '0;
			ovf_s[0] <= ovf;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_step
		localparam int SH = QW - k;
		logic [CW-1:0] trial;
		logic          take;

		assign trial = {1'b0, rem_s[k-1]} - (CW'(d_s[k-1]) << SH);
		assign take  = !trial[CW-1];

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				rem_s[k] <= take ? trial[NW-1:0] : rem_s[k-1];
				q_s[k]   <= q_s[k-1] | (QW'(take) << SH);
				d_s[k]   <= d_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	// ties go up, away from zero in magnitude
	assign r2 = {rem_s[QW], 1'b0} >= CW'(d_s[QW]);

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			qm_q <= ovf_s[QW] ? ((QW+1)'(1) << QW) : ({1'b0, q_s[QW]} + (QW+1)'(r2));
		end
	end

	assign qm    = qm_q;
	assign valid = v_q;

endmodule

[hdl/closest_point_line_to_ray_core.sv]
// closest_point_line_to_ray_core: closest point on a line to a ray's line
// built from digit-serial multipliers and a bit-per-stage divider
// throughput one item per cycle; the whole pipeline halts while a result waits
// asynchronous active-low reset clears all valid bits; no other state
`timescale 1ns / 1ps

module closest_point_line_to_ray_core #(
	parameter int COORD_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	clpr_query_if.sink    query,
	clpr_result_if.source result
);
	import clpr_pkg::*;

	localparam int N   = COORD_BITS;
	localparam int LW  = N + 1;
	localparam int PW1 = 2 * N + 2;
	localparam int SW  = 2 * N + 4;
	localparam int MPW = 2 * SW;
	localparam int MW  = MPW + 1;
	localparam int XW  = MW + LW;
	localparam int DVW = MW - 1;
	localparam int QW  = N + 1;
	localparam int M1  = (SW + MUL_DIGIT_WIDE - 1) / MUL_DIGIT_WIDE;
	localparam int M2  = (LW + MUL_DIGIT_NARROW - 1) / MUL_DIGIT_NARROW;
	localparam int P1W = 3 * N + 3 * LW;
	localparam int P2W = 3 * N + DVW + 1;
	localparam int P3W = 3 * N + 4;

	logic adv;
	logic res_v_q;

	assign adv         = !res_v_q || result.ready;
	assign query.ready = adv;

	// stage 1: differences
	logic signed [N-1:0]  org [3], dir [3], st [3], en_pt [3];
	logic signed [N-1:0]  s_s1 [3], dir_s1 [3];
	logic signed [LW-1:0] l_s1 [3], r_s1 [3];
	logic                 v_s1;

	assign org[0]   = query.ray_origin_x;
	assign org[1]   = query.ray_origin_y;
	assign org[2]   = query.ray_origin_z;
	assign dir[0]   = query.ray_dir_x;
	assign dir[1]   = query.ray_dir_y;
	assign dir[2]   = query.ray_dir_z;
	assign st[0]    = query.seg_start_x;
	assign st[1]    = query.seg_start_y;
	assign st[2]    = query.seg_start_z;
	assign en_pt[0] = query.seg_end_x;
	assign en_pt[1] = query.seg_end_y;
	assign en_pt[2] = query.seg_end_z;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				s_s1[k]   <= st[k];
				dir_s1[k] <= dir[k];
				l_s1[k]   <= LW'(en_pt[k]) - LW'(st[k]);
				r_s1[k]   <= LW'(org[k]) - LW'(st[k]);
			end
		end
	end

	// stage 2: component products
	logic signed [PW1-1:0] dd_s2 [3], dl_s2 [3], ll_s2 [3], dr_s2 [3], lr_s2 [3];
	logic signed [N-1:0]   s_s2 [3];
	logic signed [LW-1:0]  l_s2 [3];
	logic                  v_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				dd_s2[k] <= PW1'(dir_s1[k]) * PW1'(dir_s1[k]);
				dl_s2[k] <= PW1'(dir_s1[k]) * PW1'(l_s1[k]);
				ll_s2[k] <= PW1'(l_s1[k]) * PW1'(l_s1[k]);
				dr_s2[k] <= PW1'(dir_s1[k]) * PW1'(r_s1[k]);
				lr_s2[k] <= PW1'(l_s1[k]) * PW1'(r_s1[k]);
				s_s2[k]  <= s_s1[k];
				l_s2[k]  <= l_s1[k];
			end
		end
	end

	// stage 3: dot products
	logic signed [SW-1:0] a_s3, b_s3, e_s3, c_s3, f_s3;
	logic signed [N-1:0]  s_s3 [3];
	logic signed [LW-1:0] l_s3 [3];
	logic                 v_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s3 <= SW'(dd_s2[0]) + SW'(dd_s2[1]) + SW'(dd_s2[2]);
			b_s3 <= SW'(dl_s2[0]) + SW'(dl_s2[1]) + SW'(dl_s2[2]);
			e_s3 <= SW'(ll_s2[0]) + SW'(ll_s2[1]) + SW'(ll_s2[2]);
			c_s3 <= SW'(dr_s2[0]) + SW'(dr_s2[1]) + SW'(dr_s2[2]);
			f_s3 <= SW'(lr_s2[0]) + SW'(lr_s2[1]) + SW'(lr_s2[2]);
			for (int k = 0; k < 3; k++) begin
				s_s3[k] <= s_s2[k];
				l_s3[k] <= l_s2[k];
			end
		end
	end

	// determinant and numerator products
	logic signed [MPW-1:0] ae, bb, af, cb;

	clpr_mul #(.AW(SW), .BW(SW), .DGW(MUL_DIGIT_WIDE)) u_mul_ae (
		.clk(clk), .en(adv), .a(a_s3), .b(e_s3), .p(ae));
	clpr_mul #(.AW(SW), .BW(SW), .DGW(MUL_DIGIT_WIDE)) u_mul_bb (
		.clk(clk), .en(adv), .a(b_s3), .b(b_s3), .p(bb));
	clpr_mul #(.AW(SW), .BW(SW), .DGW(MUL_DIGIT_WIDE)) u_mul_af (
		.clk(clk), .en(adv), .a(a_s3), .b(f_s3), .p(af));
	clpr_mul #(.AW(SW), .BW(SW), .DGW(MUL_DIGIT_WIDE)) u_mul_cb (
		.clk(clk), .en(adv), .a(c_s3), .b(b_s3), .p(cb));

	logic [P1W-1:0] pk1, pk1_m;
	logic           v_m1;
	pipe_ctl_t      ctl1;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pk1[k*N +: N]         = s_s3[k];
			pk1[3*N + k*LW +: LW] = l_s3[k];
		end
	end

	assign ctl1 = '{en: adv, valid: v_s3};

	clpr_pipe #(.W(P1W), .DEPTH(M1)) u_pipe_m1 (
		.clk(clk), .arst_n(arst_n), .ctl(ctl1), .d(pk1), .q(pk1_m), .valid(v_m1));

	// stage 4: det and num
	logic signed [MW-1:0] det_s4, num_s4;
	logic signed [N-1:0]  s_s4 [3];
	logic signed [LW-1:0] l_s4 [3];
	logic                 v_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s4 <= MW'(ae) - MW'(bb);
			num_s4 <= MW'(af) - MW'(cb);
			for (int k = 0; k < 3; k++) begin
				s_s4[k] <= pk1_m[k*N +: N];
				l_s4[k] <= pk1_m[3*N + k*LW +: LW];
			end
		end
	end

	// num times each line component
	logic signed [XW-1:0] nl [3];

	for (genvar k = 0; k < 3; k++) begin : g_nl
		clpr_mul #(.AW(MW), .BW(LW), .DGW(MUL_DIGIT_NARROW)) u_mul_nl (
			.clk(clk), .en(adv), .a(num_s4), .b(l_s4[k]), .p(nl[k]));
	end

	logic [P2W-1:0] pk2, pk2_m;
	logic           v_m2;
	pipe_ctl_t      ctl2;

	// det is a sum of squares by the Lagrange identity, so never negative
	always_comb begin
		for (int k = 0; k < 3; k++) pk2[k*N +: N] = s_s4[k];
		pk2[3*N +: DVW] = det_s4[DVW-1:0];
		pk2[P2W-1]      = (det_s4 == '0);
	end

	assign ctl2 = '{en: adv, valid: v_s4};

	clpr_pipe #(.W(P2W), .DEPTH(M2)) u_pipe_m2 (
		.clk(clk), .arst_n(arst_n), .ctl(ctl2), .d(pk2), .q(pk2_m), .valid(v_m2));

	// stage 5: magnitudes for the divider
	logic [XW-1:0]       mag_s5 [3];
	logic                neg_s5 [3];
	logic [DVW-1:0]      dv_s5;
	logic                dz_s5;
	logic signed [N-1:0] s_s5 [3];
	logic                v_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				neg_s5[k] <= nl[k][XW-1];
				mag_s5[k] <= nl[k][XW-1] ? $unsigned(-nl[k]) : $unsigned(nl[k]);
				s_s5[k]   <= pk2_m[k*N +: N];
			end
			dv_s5 <= pk2_m[3*N +: DVW];
			dz_s5 <= pk2_m[P2W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= query.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_m1;
			v_s5 <= v_m2;
		end
	end

	// rounded quotient magnitudes
	pipe_ctl_t  ctl3;
	logic [QW:0] qm [3];
	logic        v_dv [3];

	assign ctl3 = '{en: adv, valid: v_s5};

	for (genvar k = 0; k < 3; k++) begin : g_div
		clpr_div #(.NW(XW), .DW(DVW), .QW(QW)) u_div (
			.clk(clk), .arst_n(arst_n), .ctl(ctl3), .n(mag_s5[k]), .d(dv_s5),
			.qm(qm[k]), .valid(v_dv[k]));
	end

	logic [P3W-1:0] pk3, pk3_d;
	logic           v_p3;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pk3[k*N +: N] = s_s5[k];
			pk3[3*N + k]  = neg_s5[k];
		end
		pk3[P3W-1] = dz_s5;
	end

	clpr_pipe #(.W(P3W), .DEPTH(QW + 2)) u_pipe_div (
		.clk(clk), .arst_n(arst_n), .ctl(ctl3), .d(pk3), .q(pk3_d), .valid(v_p3));

	// output stage: offset, clamp, parallel case
	logic signed [N+2:0] hi, lo;
	logic signed [N+2:0] px [3];
	logic signed [N-1:0] pc [3];
	logic                clip_k [3];
	logic                dz_d;

	assign hi   = $signed({4'b0000, {(N-1){1'b1}}});
	assign lo   = $signed({4'b1111, {(N-1){1'b0}}});
	assign dz_d = pk3_d[P3W-1];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [N+2:0] sx, qx;
			sx = (N+3)'(signed'(pk3_d[k*N +: N]));
			qx = $signed({1'b0, qm[k]});
			px[k] = pk3_d[3*N + k] ? (sx - qx) : (sx + qx);
			if (px[k] > hi) begin
				pc[k]     = hi[N-1:0];
				clip_k[k] = 1'b1;
			end else if (px[k] < lo) begin
				pc[k]     = lo[N-1:0];
				clip_k[k] = 1'b1;
			end else begin
				pc[k]     = px[k][N-1:0];
				clip_k[k] = 1'b0;
			end
		end
	end

	logic signed [N-1:0] near_q [3];
	logic                par_q, clip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (adv) begin
			res_v_q <= v_p3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				near_q[k] <= dz_d ? pk3_d[k*N +: N] : pc[k];
			end
			par_q  <= dz_d;
			clip_q <= !dz_d && (clip_k[0] || clip_k[1] || clip_k[2]);
		end
	end

	assign result.valid         = res_v_q;
	assign result.near_x        = near_q[0];
	assign result.near_y        = near_q[1];
	assign result.near_z        = near_q[2];
	assign result.parallel_flag = par_q;
	assign result.clipped_flag  = clip_q;

	// the three divider lanes and their side data stay in step
	a_div_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		(v_dv[0] == v_p3) && (v_dv[1] == v_p3) && (v_dv[2] == v_p3))
		else $error("divider lanes out of step with side data");

	// a parallel result is returned unclamped
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.parallel_flag && result.clipped_flag))
		else $error("parallel and clipped flags both set");

	// a result held under back-pressure keeps its valid and its data
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_v_q && !result.ready) |=> (res_v_q && $stable(result.near_x)))
		else $error("pipeline moved while a result was stalled");

endmodule

[bench/clpr_checker.sv]
// clpr_checker: watches the query and result channels, predicts each closest point
// depends on clpr_query_if and clpr_result_if
`timescale 1ns / 1ps

module clpr_checker #(
	parameter int COORD_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	clpr_query_if.sink    query,
	clpr_result_if.sink   result,
	output int            fail_count,
	output int            pending_points,
	output int            parallel_seen,
	output int            clipped_seen
);

	localparam int W = 8 * COORD_BITS;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
		logic                         parallel_flag;
		logic                         clipped_flag;
	} near_point_t;

	near_point_t point_queue[$];

	// exact closest point; every intermediate held at full width
	function automatic near_point_t closest_point(
		input logic signed [COORD_BITS-1:0] ox, oy, oz, dx, dy, dz,
		input logic signed [COORD_BITS-1:0] sx, sy, sz, ex, ey, ez
	);
		logic signed [W-1:0] o[3], d[3], s[3], l[3], r[3];
		logic signed [W-1:0] a, b, e, c, f, det, num, prod, q, rem, p, hi, lo;
		logic [W-1:0] ur, ud;
		near_point_t res;
		o[0] = ox; o[1] = oy; o[2] = oz;
		d[0] = dx; d[1] = dy; d[2] = dz;
		s[0] = sx; s[1] = sy; s[2] = sz;
		l[0] = ex; l[1] = ey; l[2] = ez;
		for (int k = 0; k < 3; k++) begin
			l[k] = l[k] - s[k];
			r[k] = o[k] - s[k];
		end
		a = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
		b = d[0]*l[0] + d[1]*l[1] + d[2]*l[2];
		e = l[0]*l[0] + l[1]*l[1] + l[2]*l[2];
		c = d[0]*r[0] + d[1]*r[1] + d[2]*r[2];
		f = l[0]*r[0] + l[1]*r[1] + l[2]*r[2];
		det = a*e - b*b;
		res = '0;
		if (det == 0) begin
			res.x = sx; res.y = sy; res.z = sz;
			res.parallel_flag = 1'b1;
			return res;
		end
		num = a*f - c*b;
		hi = (W'(1) <<< (COORD_BITS-1)) - 1;
		lo = -(W'(1) <<< (COORD_BITS-1));
		for (int k = 0; k < 3; k++) begin
			prod = num * l[k];
			ur = prod < 0 ? -prod : prod;
			ud = det < 0 ? -det : det;
			q = ur / ud;
			rem = ur % ud;
			// round half away from zero
			if ((rem << 1) >= ud) q = q + 1;
			if ((prod < 0) != (det < 0)) q = -q;
			p = s[k] + q;
			if (p > hi) begin
				p = hi; res.clipped_flag = 1'b1;
			end else if (p < lo) begin
				p = lo; res.clipped_flag = 1'b1;
			end
			if (k == 0) res.x = p[COORD_BITS-1:0];
			else if (k == 1) res.y = p[COORD_BITS-1:0];
			else res.z = p[COORD_BITS-1:0];
		end
		return res;
	endfunction

	assign pending_points = point_queue.size();

	always @(posedge clk or negedge arst_n) begin
		near_point_t want, got;
		if (!arst_n) begin
			fail_count    <= 0;
			parallel_seen <= 0;
			clipped_seen  <= 0;
		end else begin
			if (query.valid && query.ready)
				point_queue.push_back(closest_point(query.ray_origin_x, query.ray_origin_y,
					query.ray_origin_z, query.ray_dir_x, query.ray_dir_y, query.ray_dir_z,
					query.seg_start_x, query.seg_start_y, query.seg_start_z,
					query.seg_end_x, query.seg_end_y, query.seg_end_z));
			if (result.valid && result.ready) begin
				got = {result.near_x, result.near_y, result.near_z,
					result.parallel_flag, result.clipped_flag};
				if (point_queue.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("%t: result item with nothing expected: %h", $realtime, got);
				end else begin
					want = point_queue.pop_front();
					parallel_seen <= parallel_seen + want.parallel_flag;
					clipped_seen  <= clipped_seen + want.clipped_flag;
					if (got !== want) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("%t: mismatch exp x=%h y=%h z=%h par=%b clip=%b, got x=%h y=%h z=%h par=%b clip=%b",
								$realtime, want.x, want.y, want.z, want.parallel_flag,
								want.clipped_flag, got.x, got.y, got.z, got.parallel_flag,
								got.clipped_flag);
					end
				end
			end
		end
	end

endmodule

[bench/testbench.sv]
// testbench: drives ray and line queries into closest_point_line_to_ray_core
// depends on clpr_query_if, clpr_result_if and clpr_checker
`timescale 1ns / 1ps

module testbench;

	localparam int CB = 32;
	localparam int RANDOM_ITEMS = 1730;
	localparam int DRAIN_CYCLES = 120;

	logic clk;
	logic arst_n;
	int   fail_count, pending_points, parallel_seen, clipped_seen;
	int   sent;
	bit   calm_sink, calm_source;
	bit   hold_sink;

	clpr_query_if  #(.COORD_BITS(CB)) query ();
	clpr_result_if #(.COORD_BITS(CB)) result ();

	closest_point_line_to_ray_core #(.COORD_BITS(CB)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.query  (query.sink),
		.result (result.source)
	);

	clpr_checker #(.COORD_BITS(CB)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.query          (query.sink),
		.result         (result.sink),
		.fail_count     (fail_count),
		.pending_points (pending_points),
		.parallel_seen  (parallel_seen),
		.clipped_seen   (clipped_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mix of extremes, small values and full random bits
	function automatic logic [CB-1:0] pick_coord(input int style);
		unique case (style)
			0: return {1'b0, {(CB-1){1'b1}}};
			1: return {1'b1, {(CB-1){1'b0}}};
			2: return CB'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
			3: return CB'($signed($urandom_range(0, 8000)) - 4000) <<< 10;
			default: return CB'($urandom);
		endcase
	endfunction

	task automatic offer_query(input logic [CB-1:0] v[12]);
		query.valid        <= 1'b1;
		query.ray_origin_x <= v[0];  query.ray_origin_y <= v[1];  query.ray_origin_z <= v[2];
		query.ray_dir_x    <= v[3];  query.ray_dir_y    <= v[4];  query.ray_dir_z    <= v[5];
		query.seg_start_x  <= v[6];  query.seg_start_y  <= v[7];  query.seg_start_z  <= v[8];
		query.seg_end_x    <= v[9];  query.seg_end_y    <= v[10]; query.seg_end_z    <= v[11];
		do @(posedge clk); while (!query.ready);
		sent++;
		@(negedge clk);
		// each cycle idles on its own draw
		while (!calm_source && $urandom_range(0, 99) < 19) begin
			query.valid <= 1'b0;
			@(negedge clk);
		end
	endtask

	// receiver side idling, with a quiet stretch and a long hold-off
	initial begin
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink) result.ready <= 1'b0;
			else result.ready <= calm_sink || ($urandom_range(0, 99) >= 19);
		end
	end

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		logic [CB-1:0] v[12];
		int style;
		query.valid = 1'b0;
		query.ray_origin_x = '0; query.ray_origin_y = '0; query.ray_origin_z = '0;
		query.ray_dir_x = '0; query.ray_dir_y = '0; query.ray_dir_z = '0;
		query.seg_start_x = '0; query.seg_start_y = '0; query.seg_start_z = '0;
		query.seg_end_x = '0; query.seg_end_y = '0; query.seg_end_z = '0;
		arst_n = 1'b0;
		sent = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: perpendicular lines, parallel, zero direction, degenerate line, extremes
		for (int n = 0; n < 20; n++) begin
			foreach (v[i]) v[i] = pick_coord(2);
			unique case (n)
				0: begin
					v = '{0, 0, 32'h10000, 32'h10000, 0, 0, 0, 0, 0, 0, 32'h10000, 0};
				end
				1: for (int i = 0; i < 3; i++) v[9+i] = v[6+i] + 2 * v[3+i];
				2: for (int i = 0; i < 3; i++) v[3+i] = '0;
				3: for (int i = 0; i < 3; i++) v[9+i] = v[6+i];
				4: foreach (v[i]) v[i] = pick_coord(0);
				5: foreach (v[i]) v[i] = pick_coord(1);
				// near-parallel with far origin drives t huge
				6, 7: begin
					v[3] = 32'h10000; v[4] = 0; v[5] = 0;
					v[6] = pick_coord(n - 6); v[7] = 0; v[8] = 0;
					v[9] = v[6] + 32'h10000; v[10] = 1; v[11] = 0;
					v[0] = pick_coord(7 - n); v[1] = 32'h7fff0000; v[2] = 0;
				end
				default: foreach (v[i]) v[i] = pick_coord($urandom_range(0, 4));
			endcase
			offer_query(v);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm_sink   = (n >= 300 && n < 500);
			calm_source = calm_sink;
			if (n == 700) begin
				// drain fully with the sender paused
				query.valid <= 1'b0;
				while (pending_points != 0) @(negedge clk);
			end
			if (n == 900) begin
				fork
					begin
						hold_sink = 1'b1;
						repeat (200) @(negedge clk);
						hold_sink = 1'b0;
					end
				join_none
			end
			style = $urandom_range(0, 9);
			foreach (v[i]) v[i] = pick_coord(style < 5 ? 4 : $urandom_range(0, 4));
			if (style == 9)
				for (int i = 0; i < 3; i++) v[9+i] = v[6+i] + 3 * v[3+i];
			offer_query(v);
		end
		query.valid <= 1'b0;

		while (pending_points != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("covered %0d queries: %0d parallel or degenerate, %0d saturated",
			sent, parallel_seen, clipped_seen);
		if (fail_count == 0 && pending_points == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
